### rtl/hac_pkg.sv
// ----------------------------------------------------------------------------
// hac_pkg
// Shared widths, codes, control-word layout and microprogram for the
// accumulator machine step block.
// ----------------------------------------------------------------------------
`default_nettype none

package hac_pkg;

  // Widths of the machine
  localparam int WORD_W    = 12;
  localparam int BYTE_W    = 8;
  localparam int OP_W      = 4;
  localparam int ST_W      = 2;
  localparam int MEM_DEPTH = 256;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int DIV_STEPS = WORD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int UPC_W     = 5;

  localparam logic [WORD_W-1:0] DIV_ZERO_CODE = 12'h111;

  // Opcodes
  localparam logic [OP_W-1:0] OP_XCHG  = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
  localparam logic [OP_W-1:0] OP_STORE = 4'd2;
  localparam logic [OP_W-1:0] OP_ADDC  = 4'd3;
  localparam logic [OP_W-1:0] OP_XOR   = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
  localparam logic [OP_W-1:0] OP_PUSH  = 4'd6;
  localparam logic [OP_W-1:0] OP_POP   = 4'd7;
  localparam logic [OP_W-1:0] OP_COMP  = 4'd8;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd9;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_DIVZERO = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

  // Microprogram addresses
  localparam logic [UPC_W-1:0] UA_XCHG   = 5'd0;
  localparam logic [UPC_W-1:0] UA_LOAD0  = 5'd1;
  localparam logic [UPC_W-1:0] UA_LOAD1  = 5'd2;
  localparam logic [UPC_W-1:0] UA_STORE  = 5'd3;
  localparam logic [UPC_W-1:0] UA_ADDC   = 5'd4;
  localparam logic [UPC_W-1:0] UA_XOR    = 5'd5;
  localparam logic [UPC_W-1:0] UA_DIV0   = 5'd6;
  localparam logic [UPC_W-1:0] UA_DIV1   = 5'd7;
  localparam logic [UPC_W-1:0] UA_DIV2   = 5'd8;
  localparam logic [UPC_W-1:0] UA_DIVZ   = 5'd9;
  localparam logic [UPC_W-1:0] UA_PUSH0  = 5'd10;
  localparam logic [UPC_W-1:0] UA_PUSH1  = 5'd11;
  localparam logic [UPC_W-1:0] UA_POP0   = 5'd12;
  localparam logic [UPC_W-1:0] UA_POP1   = 5'd13;
  localparam logic [UPC_W-1:0] UA_COMP   = 5'd14;
  localparam logic [UPC_W-1:0] UA_CLEAR  = 5'd15;
  localparam logic [UPC_W-1:0] UA_NOP    = 5'd16;

  // Control word fields; the zero code of each is the no-op
  typedef enum logic [2:0] {
    A_HOLD, A_IN, A_BIN, A_SUM, A_XOR, A_INV, A_ZERO, A_MEM
  } a_sel_t;

  typedef enum logic [1:0] {
    B_HOLD, B_IN, B_AIN
  } b_sel_t;

  typedef enum logic [1:0] {
    C_HOLD, C_AIN, C_QUO, C_DZ
  } c_sel_t;

  typedef enum logic [1:0] {
    SP_HOLD, SP_INC, SP_DEC
  } sp_op_t;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_RD_ADDR, MEM_RD_SP, MEM_WR_ADDR, MEM_WR_SP
  } mem_op_t;

  typedef enum logic [1:0] {
    DIV_NONE, DIV_INIT, DIV_STEP
  } div_op_t;

  typedef enum logic [2:0] {
    STS_HOLD, STS_OK, STS_CHK_DZ, STS_CHK_FULL, STS_CHK_EMPTY
  } sts_op_t;

  typedef enum logic [1:0] {
    J_NEXT, J_BZERO, J_LOOP
  } jmp_t;

  typedef struct packed {
    a_sel_t           a_sel;
    b_sel_t           b_sel;
    c_sel_t           c_sel;
    logic             d_ld;
    logic             e_ld;
    sp_op_t           sp_op;
    mem_op_t          mem_op;
    div_op_t          div_op;
    sts_op_t          sts_op;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
    logic             done;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   exec;
    uword_t uw;
  } hac_ctl_t;

  // Datapath conditions for the sequencer's jumps
  typedef struct packed {
    logic b_zero;
    logic div_last;
  } hac_cond_t;

  // Architectural state as seen on the result channel
  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] c_reg;
    logic [WORD_W-1:0] d_reg;
    logic              carry;
    logic [BYTE_W-1:0] stack_ptr;
    logic [BYTE_W-1:0] prog_count;
    logic [ST_W-1:0]   status;
  } hac_arch_t;

  // Map an opcode to the first step of its routine
  function automatic logic [UPC_W-1:0] ucode_entry(input logic [OP_W-1:0] op);
    logic [UPC_W-1:0] ua;
    ua = UA_NOP;
    case (op)
      OP_XCHG:  ua = UA_XCHG;
      OP_LOAD:  ua = UA_LOAD0;
      OP_STORE: ua = UA_STORE;
      OP_ADDC:  ua = UA_ADDC;
      OP_XOR:   ua = UA_XOR;
      OP_DIV:   ua = UA_DIV0;
      OP_PUSH:  ua = UA_PUSH0;
      OP_POP:   ua = UA_POP0;
      OP_COMP:  ua = UA_COMP;
      OP_CLEAR: ua = UA_CLEAR;
      default:  ua = UA_NOP;
    endcase
    return ua;
  endfunction

  // Control store
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    w = '0;
    case (upc)
      UA_XCHG: begin
        w.a_sel  = A_BIN;
        w.b_sel  = B_AIN;
        w.c_sel  = C_AIN;
        w.sts_op = STS_OK;
        w.done   = 1'b1;
      end
      UA_LOAD0: begin
        w.mem_op = MEM_RD_ADDR;
        w.sts_op = STS_OK;
      end
      UA_LOAD1: begin
        w.a_sel = A_MEM;
        w.done  = 1'b1;
      end
      UA_STORE: begin
        w.mem_op = MEM_WR_ADDR;
        w.sts_op = STS_OK;
        w.done   = 1'b1;
      end
      UA_ADDC: begin
        w.a_sel  = A_SUM;
        w.b_sel  = B_IN;
        w.e_ld   = 1'b1;
        w.sts_op = STS_OK;
        w.done   = 1'b1;
      end
      UA_XOR: begin
        w.a_sel  = A_XOR;
        w.b_sel  = B_IN;
        w.sts_op = STS_OK;
        w.done   = 1'b1;
      end
      UA_DIV0: begin
        w.a_sel  = A_IN;
        w.b_sel  = B_IN;
        w.div_op = DIV_INIT;
        w.sts_op = STS_CHK_DZ;
        w.jmp    = J_BZERO;
        w.target = UA_DIVZ;
      end
      UA_DIV1: begin
        w.div_op = DIV_STEP;
        w.jmp    = J_LOOP;
        w.target = UA_DIV1;
      end
      UA_DIV2: begin
        w.c_sel = C_QUO;
        w.d_ld  = 1'b1;
        w.done  = 1'b1;
      end
      UA_DIVZ: begin
        w.c_sel = C_DZ;
        w.done  = 1'b1;
      end
      UA_PUSH0: begin
        w.a_sel  = A_IN;
        w.sp_op  = SP_INC;
        w.sts_op = STS_CHK_FULL;
      end
      UA_PUSH1: begin
        w.mem_op = MEM_WR_SP;
        w.done   = 1'b1;
      end
      UA_POP0: begin
        w.mem_op = MEM_RD_SP;
        w.sts_op = STS_CHK_EMPTY;
      end
      UA_POP1: begin
        w.a_sel = A_MEM;
        w.sp_op = SP_DEC;
        w.done  = 1'b1;
      end
      UA_COMP: begin
        w.a_sel  = A_INV;
        w.sts_op = STS_OK;
        w.done   = 1'b1;
      end
      UA_CLEAR: begin
        w.a_sel  = A_ZERO;
        w.sts_op = STS_OK;
        w.done   = 1'b1;
      end
      default: begin
        w.sts_op = STS_OK;
        w.done   = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/hac_sequencer.sv
// ----------------------------------------------------------------------------
// hac_sequencer
// Step counter and control store: dispatches on the opcode, walks the
// routine one control word per cycle and hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module hac_sequencer (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  input  wire  [hac_pkg::OP_W-1:0]       in_opcode,
  output logic                           in_ready,
  input  wire                            out_free,
  output logic                           emit,
  input  wire  hac_pkg::hac_cond_t       cond,
  output hac_pkg::hac_ctl_t              ctl
);

  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_RUN  = 3'b010,
    SQ_EMIT = 3'b100
  } sq_state_t;

  sq_state_t                   state_r, state_nxt;
  logic [hac_pkg::UPC_W-1:0]   upc_r, upc_nxt;
  hac_pkg::uword_t             uw;

  // Fetch the current control word
  assign uw       = hac_pkg::ucode_rom(upc_r);
  assign ctl.uw   = uw;
  assign ctl.exec = (state_r == SQ_RUN);
  assign in_ready = (state_r == SQ_IDLE);
  assign emit     = (state_r == SQ_EMIT) && out_free;

  // Advance the step counter
  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    case (state_r)
      SQ_IDLE: begin
        if (in_valid) begin
          state_nxt = SQ_RUN;
          upc_nxt   = hac_pkg::ucode_entry(in_opcode);
        end
      end
      SQ_RUN: begin
        if (uw.done) begin
          state_nxt = SQ_EMIT;
        end else begin
          case (uw.jmp)
            hac_pkg::J_BZERO: upc_nxt = cond.b_zero ? uw.target : upc_r + 1'b1;
            hac_pkg::J_LOOP:  upc_nxt = cond.div_last ? upc_r + 1'b1 : uw.target;
            default:          upc_nxt = upc_r + 1'b1;
          endcase
        end
      end
      SQ_EMIT: begin
        if (out_free) begin
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      upc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      upc_r   <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/hac_datapath.sv
// ----------------------------------------------------------------------------
// hac_datapath
// Machine registers, adder, shift-subtract divider and the data memory,
// all driven by the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module hac_datapath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_fire,
  input  wire  [hac_pkg::WORD_W-1:0]       in_a_value,
  input  wire  [hac_pkg::WORD_W-1:0]       in_b_value,
  input  wire  [hac_pkg::BYTE_W-1:0]       in_address,
  input  wire  hac_pkg::hac_ctl_t          ctl,
  output hac_pkg::hac_cond_t               cond,
  output hac_pkg::hac_arch_t               arch
);

  localparam int W  = hac_pkg::WORD_W;
  localparam int AW = hac_pkg::MEM_AW;

  // Operand latches
  logic [W-1:0]                  a_in_r, b_in_r;
  logic [hac_pkg::BYTE_W-1:0]    addr_r;

  // Machine registers
  logic [W-1:0]                  a_r, b_r, c_r, d_r;
  logic                          e_r;
  logic [hac_pkg::BYTE_W-1:0]    sp_r, pc_r;
  logic [hac_pkg::ST_W-1:0]      st_r;

  // Divider
  logic [W-1:0]                  rem_r, quo_r;
  logic [hac_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [W:0]                    rem_sh, rem_diff;
  logic                          rem_ge;

  // Memory
  logic [W-1:0]                  mem_q [hac_pkg::MEM_DEPTH];
  logic [hac_pkg::MEM_DEPTH-1:0] mem_vld_r;
  logic [W-1:0]                  mem_rd_r;
  logic                          rd_vld_r;
  logic [W-1:0]                  mem_word;
  logic [AW-1:0]                 addr_idx, sp_idx, rd_idx, wr_idx;
  logic                          mem_wr, mem_rd;

  logic [W:0]                    sum;
  logic                          go;
  hac_pkg::uword_t               uw;

  assign uw = ctl.uw;
  assign go = ctl.exec;

  // Capture the item's operands
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_in_r <= in_a_value;
      b_in_r <= in_b_value;
      addr_r <= in_address;
    end
  end

  // Add with carry in
  assign sum = {1'b0, a_in_r} + {1'b0, b_in_r} + {{W{1'b0}}, e_r};

  // One restoring divide step
  assign rem_sh   = {rem_r, quo_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, b_r};
  assign rem_ge   = (rem_sh >= {1'b0, b_r});

  assign cond.b_zero   = (b_in_r == '0);
  assign cond.div_last = (cnt_r == hac_pkg::DIV_CNT_W'(hac_pkg::DIV_STEPS - 1));

  // Memory addressing
  assign addr_idx = addr_r[AW-1:0];
  assign sp_idx   = sp_r[AW-1:0];
  assign rd_idx   = (uw.mem_op == hac_pkg::MEM_RD_SP) ? sp_idx : addr_idx;
  assign wr_idx   = (uw.mem_op == hac_pkg::MEM_WR_SP) ? sp_idx : addr_idx;
  assign mem_wr   = go && ((uw.mem_op == hac_pkg::MEM_WR_ADDR) ||
                           (uw.mem_op == hac_pkg::MEM_WR_SP));
  assign mem_rd   = go && ((uw.mem_op == hac_pkg::MEM_RD_ADDR) ||
                           (uw.mem_op == hac_pkg::MEM_RD_SP));
  // A word never written reads as zero
  assign mem_word = rd_vld_r ? mem_rd_r : '0;

  // Write and read the memory array
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem_q[wr_idx] <= a_r;
    end
    if (mem_rd) begin
      mem_rd_r <= mem_q[rd_idx];
    end
  end

  // Track written words; read-valid travels with the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (mem_wr) begin
        mem_vld_r[wr_idx] <= 1'b1;
      end
      if (mem_rd) begin
        rd_vld_r <= mem_vld_r[rd_idx];
      end
    end
  end

  // Divider registers
  always_ff @(posedge clk) begin
    if (go && uw.div_op == hac_pkg::DIV_INIT) begin
      rem_r <= '0;
      quo_r <= a_in_r;
      cnt_r <= '0;
    end else if (go && uw.div_op == hac_pkg::DIV_STEP) begin
      rem_r <= rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
      quo_r <= {quo_r[W-2:0], rem_ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Machine registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= '0;
      b_r  <= '0;
      c_r  <= '0;
      d_r  <= '0;
      e_r  <= 1'b0;
      sp_r <= '0;
      pc_r <= '0;
      st_r <= hac_pkg::ST_OK;
    end else if (go) begin
      case (uw.a_sel)
        hac_pkg::A_IN:   a_r <= a_in_r;
        hac_pkg::A_BIN:  a_r <= b_in_r;
        hac_pkg::A_SUM:  a_r <= sum[W-1:0];
        hac_pkg::A_XOR:  a_r <= a_in_r ^ b_in_r;
        hac_pkg::A_INV:  a_r <= ~a_in_r;
        hac_pkg::A_ZERO: a_r <= '0;
        hac_pkg::A_MEM:  a_r <= mem_word;
        default:         a_r <= a_r;
      endcase

      case (uw.b_sel)
        hac_pkg::B_IN:  b_r <= b_in_r;
        hac_pkg::B_AIN: b_r <= a_in_r;
        default:        b_r <= b_r;
      endcase

      case (uw.c_sel)
        hac_pkg::C_AIN: c_r <= a_in_r;
        hac_pkg::C_QUO: c_r <= quo_r;
        hac_pkg::C_DZ:  c_r <= hac_pkg::DIV_ZERO_CODE;
        default:        c_r <= c_r;
      endcase

      if (uw.d_ld) begin
        d_r <= rem_r;
      end
      if (uw.e_ld) begin
        e_r <= sum[W];
      end

      // Stack pointer wraps up, sticks at zero going down
      case (uw.sp_op)
        hac_pkg::SP_INC: sp_r <= sp_r + 1'b1;
        hac_pkg::SP_DEC: sp_r <= (sp_r == '0) ? sp_r : sp_r - 1'b1;
        default:         sp_r <= sp_r;
      endcase

      case (uw.sts_op)
        hac_pkg::STS_OK:        st_r <= hac_pkg::ST_OK;
        hac_pkg::STS_CHK_DZ:    st_r <= (b_in_r == '0) ? hac_pkg::ST_DIVZERO
                                                       : hac_pkg::ST_OK;
        hac_pkg::STS_CHK_FULL:  st_r <= (sp_r == '1) ? hac_pkg::ST_FULL
                                                     : hac_pkg::ST_OK;
        hac_pkg::STS_CHK_EMPTY: st_r <= (sp_r == '0) ? hac_pkg::ST_EMPTY
                                                     : hac_pkg::ST_OK;
        default:                st_r <= st_r;
      endcase

      // Program counter advances once per instruction
      if (uw.done) begin
        pc_r <= pc_r + 1'b1;
      end
    end
  end

  assign arch.acc        = a_r;
  assign arch.b_reg      = b_r;
  assign arch.c_reg      = c_r;
  assign arch.d_reg      = d_r;
  assign arch.carry      = e_r;
  assign arch.stack_ptr  = sp_r;
  assign arch.prog_count = pc_r;
  assign arch.status     = st_r;

endmodule

`default_nettype wire

### rtl/hex_accumulator_cpu_step.sv
// ----------------------------------------------------------------------------
// hex_accumulator_cpu_step
// One instruction of a 12-bit accumulator machine per item, run by a
// microcoded sequencer over a register/memory datapath.
// ----------------------------------------------------------------------------
// Each input item is one instruction; each yields one result item holding
// A, B, C, D, the carry, SP, PC and a status code after it executes. The
// block works on one instruction at a time: a new item is taken only when
// the sequencer is idle, while the previous result may still sit in the
// output register. A result is registered once the routine's last control
// word has run and the sequencer has passed its emit state. Divide runs
// the restoring divider, which retires one quotient bit per cycle over
// twelve steps; divide by zero skips it. With no output stall the
// sequencer is idle again, ready for the next item, in the cycle the
// result appears, so each item passes through idle, its routine and the
// emit state. A stalled result holds the sequencer once the next routine
// finishes. The 256-word memory reads as zero until written and needs no
// clearing after reset.
`default_nettype none

module hex_accumulator_cpu_step (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [hac_pkg::OP_W-1:0]     in_opcode,
  input  wire  [hac_pkg::WORD_W-1:0]   in_a_value,
  input  wire  [hac_pkg::WORD_W-1:0]   in_b_value,
  input  wire  [hac_pkg::BYTE_W-1:0]   in_address,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [hac_pkg::WORD_W-1:0]   out_acc,
  output logic [hac_pkg::WORD_W-1:0]   out_b_reg,
  output logic [hac_pkg::WORD_W-1:0]   out_c_reg,
  output logic [hac_pkg::WORD_W-1:0]   out_d_reg,
  output logic                         out_carry,
  output logic [hac_pkg::BYTE_W-1:0]   out_stack_ptr,
  output logic [hac_pkg::BYTE_W-1:0]   out_prog_count,
  output logic [hac_pkg::ST_W-1:0]     out_status
);

  hac_pkg::hac_ctl_t   ctl;
  hac_pkg::hac_cond_t  cond;
  hac_pkg::hac_arch_t  arch;
  hac_pkg::hac_arch_t  res_r;
  logic                out_valid_r;
  logic                out_free;
  logic                emit;
  logic                in_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  hac_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_free  (out_free),
    .emit      (emit),
    .cond      (cond),
    .ctl       (ctl)
  );

  hac_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_a_value (in_a_value),
    .in_b_value (in_b_value),
    .in_address (in_address),
    .ctl        (ctl),
    .cond       (cond),
    .arch       (arch)
  );

  // Hold the finished item until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= arch;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_acc        = res_r.acc;
  assign out_b_reg      = res_r.b_reg;
  assign out_c_reg      = res_r.c_reg;
  assign out_d_reg      = res_r.d_reg;
  assign out_carry      = res_r.carry;
  assign out_stack_ptr  = res_r.stack_ptr;
  assign out_prog_count = res_r.prog_count;
  assign out_status     = res_r.status;

endmodule

`default_nettype wire
